FILE: sv/ffa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffa_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned GEN_W   = 32;
  localparam int unsigned COOL_W  = 16;
  localparam int unsigned SIZE_W  = 15;
  localparam int unsigned HANDLE_W = 12;
  localparam int unsigned OFFS_W  = 12;
  localparam int unsigned NEED_W  = 16;

  localparam logic [COOL_W-1:0] COOL_RESET = 16'd5;

  typedef enum logic [2:0] {
    CLS_NONE = 3'd0,
    CLS_FREE = 3'd1,
    CLS_COOL = 3'd2,
    CLS_USED = 3'd3,
    CLS_MARK = 3'd4
  } class_e;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_CLEAN = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_SPACE = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEED,
    ST_RD,
    ST_EV,
    ST_SPLIT,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    PASS_SCAN,
    PASS_MERGE,
    PASS_FIT,
    PASS_FREE,
    PASS_CLEAN
  } pass_e;

endpackage

`default_nettype wire

FILE: sv/ffa_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffa_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [ffa_pkg::SIZE_W-1:0]    size_bytes;
  logic                          as_mark;
  logic [ffa_pkg::HANDLE_W-1:0]  handle;
  logic [ffa_pkg::STAMP_W-1:0]   now;

  modport source (output valid, mode, size_bytes, as_mark, handle, now, input ready);
  modport sink (input valid, mode, size_bytes, as_mark, handle, now, output ready);
endinterface

interface ffa_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ffa_pkg::OFFS_W-1:0]  payload_offset;
  logic [ffa_pkg::GEN_W-1:0]   generation;

  modport source (output valid, status, payload_offset, generation, input ready);
  modport sink (input valid, status, payload_offset, generation, output ready);
endinterface

`default_nettype wire

FILE: sv/first_fit_allocator_with_cooldown.sv
// first-fit region allocator with cooldown of freed chunks
// in_i: request beats (mode, size_bytes, as_mark, handle, now); valid/ready
// out_o: one result beat per request (status, payload_offset, generation)
// cfg_we_i/cfg_wdata_i: write cool_time only while the block is idle; not enforced
// chunk headers live in a one-port-read, one-port-write ram, one slot per unit;
// each request but a nop walks the chunk chain, reading each chunk's header from
// the ram (ST_RD) and then evaluating it (ST_EV)
// allocate makes up to three walks (expiry scan, retire and merge when something
// expired, first fit) plus a split write; free and clean make one walk
// a new request is taken once the previous result has been loaded into the
// output register, where it may still sit
// reset: region is one free chunk at unit 0, generation 1, cool_time 5;
// no clearing pass, unit 0 reads its reset value until first written
// a stalled output holds its beat; the next result waits behind it
`timescale 1ns / 1ps
`default_nettype none

module first_fit_allocator_with_cooldown #(
  parameter int unsigned REGION_UNITS = 4096,
  parameter int unsigned UNIT_BYTES   = 8,
  parameter int unsigned HEADER_UNITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [ffa_pkg::COOL_W-1:0]  cfg_wdata_i,
  ffa_in_if.sink                           in_i,
  ffa_out_if.source                        out_o
);

  localparam int unsigned AW   = $clog2(REGION_UNITS);
  localparam int unsigned LW   = $clog2(REGION_UNITS + 1);
  localparam int unsigned PW   = LW;
  localparam int unsigned EW   = (PW + 1 > ffa_pkg::HANDLE_W) ? PW + 1 : ffa_pkg::HANDLE_W;
  localparam int unsigned CW   = ((ffa_pkg::NEED_W > LW) ? ffa_pkg::NEED_W : LW) + 1;
  localparam int unsigned XW   = ffa_pkg::SIZE_W + 1;
  localparam int unsigned RSH  = XW + $clog2(UNIT_BYTES);
  localparam int unsigned MW   = XW + 2;
  localparam longint unsigned RECIP = ((64'd1 << RSH) + UNIT_BYTES - 1) / UNIT_BYTES;
  localparam logic [PW:0] R_P  = (PW + 1)'(REGION_UNITS);

  typedef struct packed {
    ffa_pkg::class_e                cls;
    logic [LW-1:0]                  len;
    logic [ffa_pkg::STAMP_W-1:0]    stamp;
  } entry_t;

  localparam int unsigned DW = $bits(entry_t);

  ffa_pkg::state_e state_q, state_d;
  ffa_pkg::pass_e  pass_q, pass_d;
  logic [PW-1:0]   pos_q, pos_d;
  logic            any_q, any_d;
  logic            seen_q, seen_d;
  logic            run_open_q, run_open_d;
  logic [PW-1:0]   run_at_q, run_at_d;
  logic [LW-1:0]   run_len_q, run_len_d;
  logic [XW-1:0]   xb_q, xb_d;
  logic [ffa_pkg::NEED_W-1:0] need_q, need_d;
  logic            mark_q, mark_d;
  logic [ffa_pkg::HANDLE_W-1:0] handle_q, handle_d;
  logic [ffa_pkg::STAMP_W-1:0]  now_q, now_d;
  logic [1:0]      mode_q, mode_d;
  logic [ffa_pkg::COOL_W-1:0]   cool_q;
  logic [ffa_pkg::GEN_W-1:0]    gen_q, gen_d;
  logic            hdr0_q;
  logic            rzero_q;
  logic [PW-1:0]   split_at_q, split_at_d;
  logic [LW-1:0]   split_len_q, split_len_d;
  logic [1:0]      res_status_q, res_status_d;
  logic [ffa_pkg::OFFS_W-1:0] res_offs_q, res_offs_d;
  logic            out_valid_q, out_valid_d;
  logic [1:0]      out_status_q, out_status_d;
  logic [ffa_pkg::OFFS_W-1:0] out_offs_q, out_offs_d;
  logic [ffa_pkg::GEN_W-1:0]  out_gen_q, out_gen_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wentry;
  logic [DW-1:0]   ram_rdata;

  entry_t          rd_ent;
  entry_t          rst_ent;
  logic [PW:0]     nxt_w;
  logic            at_end;
  logic            expired;
  logic            eff_free;
  logic            fit_hit;
  logic            do_split;
  logic            free_hit;
  logic            accept;
  logic            out_load;
  logic [ffa_pkg::GEN_W-1:0] gen_inc, gen_bump;
  logic [XW+MW-1:0] need_prod;
  logic [EW-1:0]   pay_w;
  logic [CW-1:0]   need_cx, len_cx, run_tot;

  ffa_hdr_ram #(
    .DW    (DW),
    .DEPTH (REGION_UNITS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (DW'(ram_wentry)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ffa_pkg::ST_IDLE);
  assign out_load = (state_q == ffa_pkg::ST_DONE) && (!out_valid_q || out_o.ready);

  assign rst_ent.cls   = ffa_pkg::CLS_FREE;
  assign rst_ent.len   = LW'(REGION_UNITS);
  assign rst_ent.stamp = '0;
  assign rd_ent = (rzero_q && hdr0_q) ? rst_ent : entry_t'(ram_rdata);

  assign nxt_w    = {1'b0, pos_q} + (PW + 1)'(rd_ent.len);
  assign at_end   = (rd_ent.len == '0) || (nxt_w >= R_P);
  assign expired  = (rd_ent.cls == ffa_pkg::CLS_COOL) &&
                    (({1'b0, rd_ent.stamp} + 33'(cool_q)) < {1'b0, now_q});
  assign eff_free = (rd_ent.cls == ffa_pkg::CLS_FREE) || expired;
  assign need_cx  = CW'(need_q);
  assign len_cx   = CW'(rd_ent.len);
  assign run_tot  = CW'(run_len_q) + len_cx;
  assign fit_hit  = (rd_ent.cls == ffa_pkg::CLS_FREE) && (need_cx <= len_cx);
  assign do_split = (need_cx + CW'(HEADER_UNITS)) < len_cx;
  assign pay_w    = EW'(pos_q) + EW'(HEADER_UNITS);
  assign free_hit = (pay_w == EW'(handle_q));
  assign need_prod = XW'(xb_q) * MW'(RECIP);
  assign gen_inc  = gen_q + 32'd1;
  assign gen_bump = (gen_inc == '0) ? 32'd1 : gen_inc;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ffa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (in_i.mode == ffa_pkg::MODE_NOP) ? ffa_pkg::ST_DONE : ffa_pkg::ST_NEED;
        end
      end
      ffa_pkg::ST_NEED: state_d = ffa_pkg::ST_RD;
      ffa_pkg::ST_RD:   state_d = ffa_pkg::ST_EV;
      ffa_pkg::ST_EV: begin
        case (pass_q)
          ffa_pkg::PASS_FIT: begin
            if (fit_hit && do_split) begin
              state_d = ffa_pkg::ST_SPLIT;
            end else if (fit_hit || at_end) begin
              state_d = ffa_pkg::ST_DONE;
            end else begin
              state_d = ffa_pkg::ST_RD;
            end
          end
          ffa_pkg::PASS_FREE:  state_d = (free_hit || at_end) ? ffa_pkg::ST_DONE : ffa_pkg::ST_RD;
          ffa_pkg::PASS_CLEAN: state_d = at_end ? ffa_pkg::ST_DONE : ffa_pkg::ST_RD;
          default:             state_d = ffa_pkg::ST_RD;
        endcase
      end
      ffa_pkg::ST_SPLIT: state_d = ffa_pkg::ST_DONE;
      ffa_pkg::ST_DONE: begin
        if (out_load) begin
          state_d = ffa_pkg::ST_IDLE;
        end
      end
      default: state_d = ffa_pkg::ST_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    pass_d       = pass_q;
    pos_d        = pos_q;
    any_d        = any_q;
    seen_d       = seen_q;
    run_open_d   = run_open_q;
    run_at_d     = run_at_q;
    run_len_d    = run_len_q;
    xb_d         = xb_q;
    need_d       = need_q;
    mark_d       = mark_q;
    handle_d     = handle_q;
    now_d        = now_q;
    mode_d       = mode_q;
    gen_d        = gen_q;
    split_at_d   = split_at_q;
    split_len_d  = split_len_q;
    res_status_d = res_status_q;
    res_offs_d   = res_offs_q;
    out_status_d = out_status_q;
    out_offs_d   = out_offs_q;
    out_gen_d    = out_gen_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    ram_we       = 1'b0;
    ram_waddr    = pos_q[AW-1:0];
    ram_wentry   = rd_ent;
    ram_re       = 1'b0;
    ram_raddr    = pos_q[AW-1:0];

    case (state_q)
      ffa_pkg::ST_IDLE: begin
        if (accept) begin
          mode_d       = in_i.mode;
          xb_d         = XW'(in_i.size_bytes) + XW'(UNIT_BYTES - 1);
          mark_d       = in_i.as_mark;
          handle_d     = in_i.handle;
          now_d        = in_i.now;
          res_status_d = ffa_pkg::STATUS_OK;
          res_offs_d   = '0;
          any_d        = 1'b0;
          seen_d       = 1'b0;
          run_open_d   = 1'b0;
          pos_d        = '0;
        end
      end
      ffa_pkg::ST_NEED: begin
        need_d = ffa_pkg::NEED_W'(need_prod >> RSH) + ffa_pkg::NEED_W'(HEADER_UNITS);
        case (mode_q)
          ffa_pkg::MODE_ALLOC: pass_d = ffa_pkg::PASS_SCAN;
          ffa_pkg::MODE_FREE:  pass_d = ffa_pkg::PASS_FREE;
          default:             pass_d = ffa_pkg::PASS_CLEAN;
        endcase
      end
      ffa_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      ffa_pkg::ST_EV: begin
        case (pass_q)
          ffa_pkg::PASS_SCAN: begin
            if (expired) begin
              any_d = 1'b1;
            end
            if (at_end) begin
              pos_d  = '0;
              pass_d = (any_q || expired) ? ffa_pkg::PASS_MERGE : ffa_pkg::PASS_FIT;
            end else begin
              pos_d = nxt_w[PW-1:0];
            end
          end
          ffa_pkg::PASS_MERGE: begin
            ram_wentry.cls   = ffa_pkg::CLS_FREE;
            ram_wentry.stamp = '0;
            if (eff_free) begin
              if (run_open_q) begin
                run_len_d = LW'(run_tot);
              end else begin
                run_open_d = 1'b1;
                run_at_d   = pos_q;
                run_len_d  = rd_ent.len;
              end
              if (at_end) begin
                ram_we         = 1'b1;
                ram_waddr      = run_open_q ? run_at_q[AW-1:0] : pos_q[AW-1:0];
                ram_wentry.len = run_open_q ? LW'(run_tot) : rd_ent.len;
              end
            end else if (run_open_q) begin
              // close the run of free chunks ahead of this one
              run_open_d     = 1'b0;
              ram_we         = 1'b1;
              ram_waddr      = run_at_q[AW-1:0];
              ram_wentry.len = run_len_q;
            end
            if (at_end) begin
              pos_d      = '0;
              pass_d     = ffa_pkg::PASS_FIT;
              run_open_d = 1'b0;
              gen_d      = gen_bump;
            end else begin
              pos_d = nxt_w[PW-1:0];
            end
          end
          ffa_pkg::PASS_FIT: begin
            if (fit_hit) begin
              ram_we           = 1'b1;
              ram_wentry.cls   = mark_q ? ffa_pkg::CLS_MARK : ffa_pkg::CLS_USED;
              ram_wentry.stamp = '0;
              ram_wentry.len   = do_split ? LW'(need_q) : rd_ent.len;
              split_at_d       = pos_q + PW'(need_q);
              split_len_d      = rd_ent.len - LW'(need_q);
              gen_d            = gen_bump;
              res_status_d     = ffa_pkg::STATUS_OK;
              res_offs_d       = pay_w[ffa_pkg::OFFS_W-1:0];
            end else if (at_end) begin
              res_status_d = ffa_pkg::STATUS_NO_SPACE;
            end else begin
              pos_d = nxt_w[PW-1:0];
            end
          end
          ffa_pkg::PASS_FREE: begin
            if (free_hit) begin
              ram_we           = 1'b1;
              ram_wentry.cls   = ffa_pkg::CLS_COOL;
              ram_wentry.stamp = now_q;
              gen_d            = gen_bump;
              res_status_d     = ffa_pkg::STATUS_OK;
            end else if (at_end) begin
              res_status_d = ffa_pkg::STATUS_NOT_FOUND;
            end else begin
              pos_d = nxt_w[PW-1:0];
            end
          end
          ffa_pkg::PASS_CLEAN: begin
            if (!seen_q) begin
              if (rd_ent.cls == ffa_pkg::CLS_MARK) begin
                seen_d = 1'b1;
              end
            end else if (rd_ent.cls == ffa_pkg::CLS_USED || rd_ent.cls == ffa_pkg::CLS_MARK) begin
              ram_we           = 1'b1;
              ram_wentry.cls   = ffa_pkg::CLS_COOL;
              ram_wentry.stamp = now_q;
            end
            if (at_end) begin
              gen_d = gen_bump;
            end else begin
              pos_d = nxt_w[PW-1:0];
            end
          end
          default: begin
          end
        endcase
      end
      ffa_pkg::ST_SPLIT: begin
        ram_we           = 1'b1;
        ram_waddr        = split_at_q[AW-1:0];
        ram_wentry.cls   = ffa_pkg::CLS_FREE;
        ram_wentry.len   = split_len_q;
        ram_wentry.stamp = '0;
      end
      ffa_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_offs_d   = res_offs_q;
          out_gen_d    = gen_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffa_pkg::ST_IDLE;
      pass_q      <= ffa_pkg::PASS_SCAN;
      any_q       <= 1'b0;
      seen_q      <= 1'b0;
      run_open_q  <= 1'b0;
      cool_q      <= ffa_pkg::COOL_RESET;
      gen_q       <= 32'd1;
      hdr0_q      <= 1'b1;
      rzero_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      any_q       <= any_d;
      seen_q      <= seen_d;
      run_open_q  <= run_open_d;
      gen_q       <= gen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cool_q <= cfg_wdata_i;
      end
      if (ram_we && ram_waddr == '0) begin
        hdr0_q <= 1'b0;
      end
      if (ram_re) begin
        rzero_q <= (ram_raddr == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    run_at_q     <= run_at_d;
    run_len_q    <= run_len_d;
    xb_q         <= xb_d;
    need_q       <= need_d;
    mark_q       <= mark_d;
    handle_q     <= handle_d;
    now_q        <= now_d;
    mode_q       <= mode_d;
    split_at_q   <= split_at_d;
    split_len_q  <= split_len_d;
    res_status_q <= res_status_d;
    res_offs_q   <= res_offs_d;
    out_status_q <= out_status_d;
    out_offs_q   <= out_offs_d;
    out_gen_q    <= out_gen_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.payload_offset = out_offs_q;
  assign out_o.generation     = out_gen_q;

  a_gen_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_q != '0)
    else $error("generation count reached zero");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ffa_pkg::ST_IDLE)
    else $error("accepted beat did not start a request");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ffa_pkg::ST_DONE))
    else $error("result beat raised outside done");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> state_q == ffa_pkg::ST_IDLE)
    else $error("result loaded without finishing the request");

endmodule

`default_nettype wire

FILE: sv/ffa_hdr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ffa_hdr_ram #(
  parameter int unsigned DW    = 51,
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sim/first_fit_allocator_with_cooldown_tb.sv
`timescale 1ns / 1ps

module first_fit_allocator_with_cooldown_tb;

  localparam int unsigned REGION = 4096;
  localparam int unsigned UBYTES = 8;
  localparam int unsigned HDR = 16;
  localparam int unsigned IDLE_LIMIT = 200000;

  typedef struct packed {
    ffa_pkg::status_e status;
    logic [ffa_pkg::OFFS_W-1:0] offset;
    logic [ffa_pkg::GEN_W-1:0] gen;
  } alloc_result_t;

  class alloc_scoreboard;
    ffa_pkg::class_e cls[REGION];
    int unsigned len[REGION];
    logic [31:0] stamp[REGION];
    logic [ffa_pkg::GEN_W-1:0] gen;
    logic [ffa_pkg::COOL_W-1:0] cool;
    alloc_result_t pending[$];
    int unsigned mismatches;
    int unsigned matched;
    int unsigned allocs_ok;
    int unsigned no_space;
    int unsigned not_found;

    function new();
      for (int i = 0; i < REGION; i++) begin
        cls[i] = ffa_pkg::CLS_NONE;
        len[i] = 0;
        stamp[i] = '0;
      end
      cls[0] = ffa_pkg::CLS_FREE;
      len[0] = REGION;
      gen = 1;
      cool = ffa_pkg::COOL_RESET;
      mismatches = 0;
      matched = 0;
      allocs_ok = 0;
      no_space = 0;
      not_found = 0;
    endfunction

    function void bump();
      gen = gen + 1;
      if (gen == 0) gen = 1;
    endfunction

    function int unsigned after(int unsigned u);
      return (len[u] == 0) ? REGION : u + len[u];
    endfunction

    function bit expired(int unsigned u, logic [31:0] t);
      return ({32'd0, stamp[u]} + {48'd0, cool}) < {32'd0, t};
    endfunction

    function void retire_merge(logic [31:0] t);
      bit any;
      int unsigned u;
      int unsigned n;
      any = 0;
      for (u = 0; u < REGION; u = after(u))
        if (cls[u] == ffa_pkg::CLS_COOL && expired(u, t)) any = 1;
      if (!any) return;
      for (u = 0; u < REGION; u = after(u))
        if (cls[u] == ffa_pkg::CLS_COOL && expired(u, t)) begin
          cls[u] = ffa_pkg::CLS_FREE;
          stamp[u] = '0;
        end
      for (u = 0; u < REGION; u = after(u)) begin
        if (cls[u] != ffa_pkg::CLS_FREE) continue;
        forever begin
          n = after(u);
          if (n >= REGION || cls[n] != ffa_pkg::CLS_FREE) break;
          len[u] += len[n];
          cls[n] = ffa_pkg::CLS_NONE;
          len[n] = 0;
          stamp[n] = '0;
        end
      end
      bump();
    endfunction

    function void note_request(ffa_pkg::mode_e m, logic [ffa_pkg::SIZE_W-1:0] sz, logic mk,
                               logic [ffa_pkg::HANDLE_W-1:0] h, logic [31:0] t);
      alloc_result_t r;
      int unsigned u;
      int unsigned need;
      int unsigned rest;
      bit seen;
      r.status = ffa_pkg::STATUS_OK;
      r.offset = '0;
      case (m)
        ffa_pkg::MODE_ALLOC: begin
          retire_merge(t);
          need = (int'(sz) + UBYTES - 1) / UBYTES + HDR;
          r.status = ffa_pkg::STATUS_NO_SPACE;
          for (u = 0; u < REGION; u = after(u)) begin
            if (cls[u] != ffa_pkg::CLS_FREE || need > len[u]) continue;
            if (need + HDR < len[u]) begin
              rest = u + need;
              cls[rest] = ffa_pkg::CLS_FREE;
              len[rest] = len[u] - need;
              stamp[rest] = '0;
              len[u] = need;
            end
            cls[u] = mk ? ffa_pkg::CLS_MARK : ffa_pkg::CLS_USED;
            stamp[u] = '0;
            bump();
            r.status = ffa_pkg::STATUS_OK;
            r.offset = ffa_pkg::OFFS_W'(u + HDR);
            break;
          end
          if (r.status == ffa_pkg::STATUS_OK) allocs_ok++;
          else no_space++;
        end
        ffa_pkg::MODE_FREE: begin
          r.status = ffa_pkg::STATUS_NOT_FOUND;
          for (u = 0; u < REGION; u = after(u))
            if (u + HDR == h) begin
              cls[u] = ffa_pkg::CLS_COOL;
              stamp[u] = t;
              bump();
              r.status = ffa_pkg::STATUS_OK;
              break;
            end
          if (r.status != ffa_pkg::STATUS_OK) not_found++;
        end
        ffa_pkg::MODE_CLEAN: begin
          seen = 0;
          for (u = 0; u < REGION; u = after(u)) begin
            if (!seen) begin
              if (cls[u] == ffa_pkg::CLS_MARK) seen = 1;
              continue;
            end
            if (cls[u] == ffa_pkg::CLS_USED || cls[u] == ffa_pkg::CLS_MARK) begin
              cls[u] = ffa_pkg::CLS_COOL;
              stamp[u] = t;
            end
          end
          bump();
        end
        default: ;
      endcase
      r.gen = gen;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [ffa_pkg::OFFS_W-1:0] off,
                               logic [ffa_pkg::GEN_W-1:0] g);
      alloc_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d offset %0d gen %0d",
          st, off, g);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || off !== e.offset || g !== e.gen) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected status %0d offset %0d gen %0d, got %0d %0d %0d",
            e.status, e.offset, e.gen, st, off, g);
      end else begin
        matched++;
      end
    endfunction

    function int unsigned live_payload();
      int unsigned picks[$];
      for (int unsigned u = 0; u < REGION; u = after(u))
        if (cls[u] != ffa_pkg::CLS_NONE) picks.push_back(u + HDR);
      return picks[$urandom_range(picks.size() - 1, 0)];
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [ffa_pkg::COOL_W-1:0] cfg_wdata_i = '0;

  ffa_in_if req_if ();
  ffa_out_if rsp_if ();

  first_fit_allocator_with_cooldown DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i(req_if.sink),
    .out_o(rsp_if.source)
  );

  alloc_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] clock_now = 0;
  int unsigned beats_in = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    req_if.valid = 0;
    req_if.mode = '0;
    req_if.size_bytes = '0;
    req_if.as_mark = 0;
    req_if.handle = '0;
    req_if.now = '0;
    rsp_if.ready = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.status, rsp_if.payload_offset, rsp_if.generation);
      if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_request(ffa_pkg::mode_e m, int unsigned sz, bit mk, int unsigned h,
                              logic [31:0] t);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid <= 0;
      @(posedge clk_i);
    end
    req_if.valid <= 1;
    req_if.mode <= m;
    req_if.size_bytes <= ffa_pkg::SIZE_W'(sz);
    req_if.as_mark <= mk;
    req_if.handle <= ffa_pkg::HANDLE_W'(h);
    req_if.now <= t;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(m, ffa_pkg::SIZE_W'(sz), mk, ffa_pkg::HANDLE_W'(h), t);
    beats_in++;
  endtask

  task automatic drain();
    req_if.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cool(logic [ffa_pkg::COOL_W-1:0] v);
    drain();
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.cool = v;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned sz;
    clock_now = clock_now + $urandom_range(3, 0);
    pick = $urandom_range(99, 0);
    if (pick < 45) begin
      sz = ($urandom_range(9, 0) == 0) ? $urandom_range(32767, 0) : $urandom_range(600, 0);
      send_request(ffa_pkg::MODE_ALLOC, sz, $urandom_range(5, 0) == 0, $urandom, clock_now);
    end else if (pick < 80) begin
      send_request(ffa_pkg::MODE_FREE, $urandom, $urandom, sb.live_payload(), clock_now);
    end else if (pick < 88) begin
      send_request(ffa_pkg::MODE_FREE, $urandom, $urandom, $urandom_range(4095, 0), clock_now);
    end else if (pick < 95) begin
      send_request(ffa_pkg::MODE_CLEAN, $urandom, $urandom, $urandom, clock_now);
    end else begin
      send_request(ffa_pkg::MODE_NOP, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_request(ffa_pkg::MODE_ALLOC, 0, 0, 0, 0);
    send_request(ffa_pkg::MODE_ALLOC, 1, 1, 0, 1);
    send_request(ffa_pkg::MODE_ALLOC, 32767, 0, 0, 2);
    send_request(ffa_pkg::MODE_ALLOC, 8, 0, 0, 2);
    send_request(ffa_pkg::MODE_ALLOC, 100, 1, 0, 3);
    send_request(ffa_pkg::MODE_FREE, 0, 0, 4095, 3);
    send_request(ffa_pkg::MODE_FREE, 0, 0, 0, 3);
    send_request(ffa_pkg::MODE_FREE, 0, 0, 32, 4);
    send_request(ffa_pkg::MODE_FREE, 0, 0, 16, 4);
    send_request(ffa_pkg::MODE_ALLOC, 10, 0, 0, 9);
    send_request(ffa_pkg::MODE_ALLOC, 10, 0, 0, 10);
    send_request(ffa_pkg::MODE_CLEAN, 0, 0, 0, 11);
    send_request(ffa_pkg::MODE_ALLOC, 5000, 0, 0, 30);
    send_request(ffa_pkg::MODE_NOP, 32767, 1, 4095, 32'hffff_ffff);
    send_request(ffa_pkg::MODE_FREE, 0, 0, sb.live_payload(), 32'hffff_fff0);
    send_request(ffa_pkg::MODE_ALLOC, 7, 0, 0, 32'hffff_ffff);
    clock_now = 100;

    write_cool(16'hffff);
    send_request(ffa_pkg::MODE_FREE, 0, 0, sb.live_payload(), 32'hffff_0000);
    send_request(ffa_pkg::MODE_ALLOC, 16, 0, 0, 32'hffff_ffff);
    send_request(ffa_pkg::MODE_ALLOC, 16, 0, 0, 32'h0);
    drain();
    write_cool(0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 59; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 59; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int i = 0; i < 120; i++) begin
        if (i == 60) begin
          drain();
          sb.pending.delete();
        end
        random_item();
      end
      write_cool(ph == 0 ? 16'd3 : ph == 1 ? 16'd40 : ph == 2 ? 16'd0 : 16'd5);
    end

    drain();
    $display("run covered %0d requests: %0d allocations, %0d no-space, %0d unknown handles",
      beats_in, sb.allocs_ok, sb.no_space, sb.not_found);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
